FILE: hdl/mhl_pkg.sv
package mhl_pkg;

   localparam int MAX_PAIRS = 5;
   localparam int FRAC_BITS = 24;

   localparam int LON_W     = FRAC_BITS + 10;
   localparam int LAT_W     = FRAC_BITS + 9;
   localparam int LON_OUT_W = 33;
   localparam int LAT_OUT_W = 32;
   localparam int PAIRS_W   = 4;
   localparam int PC_W      = $clog2(MAX_PAIRS + 1);
   localparam int CELL_N    = 2 ** PC_W;
   localparam int DIG_W     = 5;
   localparam int CHAR_W    = 8;

   localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_UP_A  = "A";
   localparam logic [CHAR_W-1:0] CH_UP_R  = "R";
   localparam logic [CHAR_W-1:0] CH_UP_X  = "X";
   localparam logic [CHAR_W-1:0] CH_LO_A  = "a";
   localparam logic [CHAR_W-1:0] CH_LO_Z  = "z";
   localparam logic [CHAR_W-1:0] CH_ZERO  = "0";
   localparam logic [CHAR_W-1:0] CH_NINE  = "9";
   localparam logic [CHAR_W-1:0] CASE_GAP = 8'd32;

   localparam logic signed [LON_W-1:0] LON_MAX = LON_W'(64'sd180 <<< FRAC_BITS);
   localparam logic signed [LON_W-1:0] LON_MIN = -LON_MAX;
   localparam logic signed [LAT_W-1:0] LAT_MAX = LAT_W'(64'sd90 <<< FRAC_BITS);
   localparam logic signed [LAT_W-1:0] LAT_MIN = -LAT_MAX;

   typedef enum logic [2:0] {
      ST_OK,
      ST_BAD_LEN,
      ST_BAD_FIELD,
      ST_BAD_LETTER,
      ST_BAD_DIGIT,
      ST_TOO_LONG
   } status_type;

   typedef logic [LON_W-1:0] lon_tab_type [0:CELL_N-1];
   typedef logic [LAT_W-1:0] lat_tab_type [0:CELL_N-1];

   typedef struct packed {
      logic signed [LON_W-1:0] lon_accum;
      logic signed [LAT_W-1:0] lat_accum;
      logic [PC_W-1:0]         pair_count;
      status_type              status;
   } fin_type;

   // cell size after k decoded pairs
   function automatic lon_tab_type build_lon_tab();
      lon_tab_type t;
      logic [63:0] v;
      v = 64'd20 << FRAC_BITS;
      for (int k = 0; k < CELL_N; k++) begin
         if (k == 0) begin
            t[k] = LON_W'(64'd360 << FRAC_BITS);
         end else if (k == 1) begin
            t[k] = LON_W'(v);
         end else if (k <= MAX_PAIRS) begin
            v = ((k % 2) == 0) ? v / 10 : v / 24;
            t[k] = LON_W'(v);
         end else begin
            t[k] = '0;
         end
      end
      return t;
   endfunction

   function automatic lat_tab_type build_lat_tab();
      lat_tab_type t;
      logic [63:0] v;
      v = 64'd10 << FRAC_BITS;
      for (int k = 0; k < CELL_N; k++) begin
         if (k == 0) begin
            t[k] = LAT_W'(64'd180 << FRAC_BITS);
         end else if (k == 1) begin
            t[k] = LAT_W'(v);
         end else if (k <= MAX_PAIRS) begin
            v = ((k % 2) == 0) ? v / 10 : v / 24;
            t[k] = LAT_W'(v);
         end else begin
            t[k] = '0;
         end
      end
      return t;
   endfunction

   localparam lon_tab_type CELL_LON = build_lon_tab();
   localparam lat_tab_type CELL_LAT = build_lat_tab();

endpackage

FILE: hdl/mhl_req_if.sv
interface mhl_req_if;
   import mhl_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] grid_char;
   logic              last;

   modport source(output valid, output grid_char, output last, input ready);
   modport sink(input valid, input grid_char, input last, output ready);
endinterface

FILE: hdl/mhl_rsp_if.sv
interface mhl_rsp_if;
   import mhl_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [LAT_OUT_W-1:0] lat_fixed;
   logic signed [LON_OUT_W-1:0] lon_fixed;
   status_type                  status;
   logic [PAIRS_W-1:0]          pairs_used;

   modport source(output valid, output lat_fixed, output lon_fixed, output status,
                  output pairs_used, input ready);
   modport sink(input valid, input lat_fixed, input lon_fixed, input status,
                input pairs_used, output ready);
endinterface

FILE: hdl/mhl_decode.sv
module mhl_decode (
   input  logic            clock,
   input  logic            reset,
   mhl_req_if.sink         req_ch,
   input  logic            out_free,
   output logic            fin_valid,
   output mhl_pkg::fin_type fin
);
   import mhl_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] char_ff;
   logic              last_ff;

   logic                    half_ff, half_in;
   logic [CHAR_W-1:0]       first_ff, first_in;
   logic [PC_W-1:0]         pc_ff, pc_in;
   logic signed [LON_W-1:0] lon_ff, lon_in;
   logic signed [LAT_W-1:0] lat_ff, lat_in;
   status_type              err_ff, err_in;
   logic [1:0]              seen_ff, seen_in;

   logic    fin_valid_ff, fin_valid_in;
   fin_type fin_ff, fin_in;

   logic              take;
   logic              blank;
   logic              pair_done;
   logic              step_ok;
   logic [CHAR_W-1:0] cur_up, first_up;
   logic [DIG_W-1:0]  dlon, dlat;
   logic [PC_W-1:0]   next_idx;
   logic [LON_W-1:0]  lon_step;
   logic [LAT_W-1:0]  lat_step;

   function automatic logic [CHAR_W-1:0] fold_upper(input logic [CHAR_W-1:0] c);
      return (c >= CH_LO_A && c <= CH_LO_Z) ? c - CASE_GAP : c;
   endfunction

   assign take         = in_valid_ff && (!last_ff || !fin_valid_ff || out_free);
   assign req_ch.ready = !in_valid_ff || take;
   assign in_valid_in  = req_ch.ready ? req_ch.valid : in_valid_ff;

   always_comb begin
      blank     = (char_ff == CH_SPACE) || (char_ff >= CH_TAB && char_ff <= CH_CR);
      cur_up    = fold_upper(char_ff);
      first_up  = fold_upper(first_ff);
      pair_done = !blank && half_ff;
      half_in   = blank ? half_ff : !half_ff;
      first_in  = (!blank && !half_ff) ? char_ff : first_ff;
      seen_in   = (pair_done && seen_ff != 2'd2) ? seen_ff + 2'd1 : seen_ff;
      next_idx  = pc_ff + PC_W'(1);
      pc_in     = pc_ff;
      err_in    = err_ff;
      dlon      = '0;
      dlat      = '0;
      step_ok   = 1'b0;
      if (pair_done && err_ff == ST_OK) begin
         if (pc_ff >= PC_W'(MAX_PAIRS)) begin
            err_in = ST_TOO_LONG;
         end else if (pc_ff == '0) begin
            if (first_up >= CH_UP_A && first_up <= CH_UP_R &&
                cur_up >= CH_UP_A && cur_up <= CH_UP_R) begin
               dlon    = DIG_W'(first_up - CH_UP_A);
               dlat    = DIG_W'(cur_up - CH_UP_A);
               step_ok = 1'b1;
            end else begin
               err_in = ST_BAD_FIELD;
            end
         end else if (pc_ff[0]) begin
            if (first_ff >= CH_ZERO && first_ff <= CH_NINE &&
                char_ff >= CH_ZERO && char_ff <= CH_NINE) begin
               dlon    = DIG_W'(first_ff - CH_ZERO);
               dlat    = DIG_W'(char_ff - CH_ZERO);
               step_ok = 1'b1;
            end else begin
               err_in = ST_BAD_DIGIT;
            end
         end else begin
            if (first_up >= CH_UP_A && first_up <= CH_UP_X &&
                cur_up >= CH_UP_A && cur_up <= CH_UP_X) begin
               dlon    = DIG_W'(first_up - CH_UP_A);
               dlat    = DIG_W'(cur_up - CH_UP_A);
               step_ok = 1'b1;
            end else begin
               err_in = ST_BAD_LETTER;
            end
         end
      end
      lon_step = LON_W'(dlon * CELL_LON[next_idx]);
      lat_step = LAT_W'(dlat * CELL_LAT[next_idx]);
      lon_in   = lon_ff;
      lat_in   = lat_ff;
      if (step_ok) begin
         lon_in = lon_ff + $signed(lon_step);
         lat_in = lat_ff + $signed(lat_step);
         pc_in  = next_idx;
      end

      fin_in.lon_accum  = lon_in;
      fin_in.lat_accum  = lat_in;
      fin_in.pair_count = pc_in;
      fin_in.status     = (half_in || seen_in != 2'd2) ? ST_BAD_LEN : err_in;

      if (take && last_ff) begin
         fin_valid_in = 1'b1;
      end else if (out_free) begin
         fin_valid_in = 1'b0;
      end else begin
         fin_valid_in = fin_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         char_ff <= req_ch.grid_char;
         last_ff <= req_ch.last;
      end
      if (take && last_ff) begin
         fin_ff <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (take && last_ff)) begin
         half_ff  <= 1'b0;
         first_ff <= '0;
         pc_ff    <= '0;
         lon_ff   <= LON_MIN;
         lat_ff   <= LAT_MIN;
         err_ff   <= ST_OK;
         seen_ff  <= 2'd0;
      end else if (take) begin
         half_ff  <= half_in;
         first_ff <= first_in;
         pc_ff    <= pc_in;
         lon_ff   <= lon_in;
         lat_ff   <= lat_in;
         err_ff   <= err_in;
         seen_ff  <= seen_in;
      end
   end

   assign fin_valid = fin_valid_ff;
   assign fin       = fin_ff;

endmodule

FILE: hdl/mhl_finish.sv
module mhl_finish (
   input  logic             clock,
   input  logic             reset,
   input  logic             fin_valid,
   input  mhl_pkg::fin_type fin,
   output logic             out_free,
   mhl_rsp_if.source        rsp_ch
);
   import mhl_pkg::*;

   logic                        valid_ff, valid_in;
   logic signed [LAT_OUT_W-1:0] lat_ff, lat_in;
   logic signed [LON_OUT_W-1:0] lon_ff, lon_in;
   status_type                  status_ff;
   logic [PAIRS_W-1:0]          pairs_ff;

   logic                    load;
   logic signed [LON_W-1:0] lon_sum, lon_clip;
   logic signed [LAT_W-1:0] lat_sum, lat_clip;
   logic [LON_W-1:0]        lon_cell;
   logic [LAT_W-1:0]        lat_cell;

   assign out_free = !valid_ff || rsp_ch.ready;
   assign load     = fin_valid && out_free;
   assign valid_in = load ? 1'b1 : (rsp_ch.ready ? 1'b0 : valid_ff);

   always_comb begin
      lon_cell = CELL_LON[fin.pair_count];
      lat_cell = CELL_LAT[fin.pair_count];
      lon_sum  = fin.lon_accum + $signed({1'b0, lon_cell[LON_W-1:1]});
      lat_sum  = fin.lat_accum + $signed({1'b0, lat_cell[LAT_W-1:1]});
      lon_clip = lon_sum;
      if (lon_sum < LON_MIN) begin
         lon_clip = LON_MIN;
      end else if (lon_sum > LON_MAX) begin
         lon_clip = LON_MAX;
      end
      lat_clip = lat_sum;
      if (lat_sum < LAT_MIN) begin
         lat_clip = LAT_MIN;
      end else if (lat_sum > LAT_MAX) begin
         lat_clip = LAT_MAX;
      end
      if (fin.status == ST_OK) begin
         lon_in = LON_OUT_W'(lon_clip);
         lat_in = LAT_OUT_W'(lat_clip);
      end else begin
         lon_in = '0;
         lat_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lat_ff    <= lat_in;
         lon_ff    <= lon_in;
         status_ff <= fin.status;
         pairs_ff  <= PAIRS_W'(fin.pair_count);
      end
   end

   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.lat_fixed  = lat_ff;
   assign rsp_ch.lon_fixed  = lon_ff;
   assign rsp_ch.status     = status_ff;
   assign rsp_ch.pairs_used = pairs_ff;

endmodule

FILE: hdl/maidenhead_locator_to_latlon_unit.sv
// Maidenhead locator decoder: characters in, cell-centre position out.
// req_ch carries one ASCII character per request with a last flag; blanks
// are skipped and the rest are decoded in pairs as they arrive.
// rsp_ch carries one result per locator, after the request flagged last:
// latitude and longitude in degrees with 24 fraction bits, a status code
// (first error seen, bad length taking precedence) and the pairs decoded.
// Throughput: one request per cycle, including across locators, unless a stall on rsp_ch backs up the path.
// The last request passes through the input register, the decode register
// and the result register before its result is valid on rsp_ch.
// The pair decode is one small multiply by a cell size taken from a
// constant table, then an add; the result stage adds half a cell and clamps.
// Reset empties all three registers and restarts the locator state; the
// locator state also restarts on its own after each last request.
// If the receiver stalls, the finished result holds on rsp_ch and requests
// keep flowing while a second finished locator waits behind it; once the last
// request of a third locator reaches the input register, req_ch.ready drops
// until rsp_ch.ready frees the result register.
module maidenhead_locator_to_latlon_unit (
   input  logic      clock,
   input  logic      reset,
   mhl_req_if.sink   req_ch,
   mhl_rsp_if.source rsp_ch
);
   import mhl_pkg::*;

   logic    fin_valid;
   logic    out_free;
   fin_type fin;

   mhl_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .out_free  (out_free),
      .fin_valid (fin_valid),
      .fin       (fin)
   );

   mhl_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .fin_valid (fin_valid),
      .fin       (fin),
      .out_free  (out_free),
      .rsp_ch    (rsp_ch)
   );

endmodule

FILE: tb/sv/mhl_locator_checker.sv
`timescale 1ns / 1ps

module mhl_locator_checker (
   input  logic clock,
   input  logic reset,
   mhl_req_if   req_mon,
   mhl_rsp_if   rsp_mon,
   output int   fail_count,
   output int   fixes_pending,
   output int   fixes_checked,
   output int   fixes_good
);
   import mhl_pkg::*;

   localparam longint ONE_DEG = longint'(1) <<< FRAC_BITS;

   typedef struct packed {
      logic signed [LAT_OUT_W-1:0] lat;
      logic signed [LON_OUT_W-1:0] lon;
      status_type                  status;
      logic [PAIRS_W-1:0]          pairs;
   } fix_type;

   fix_type fix_q[$];

   logic [PAIRS_W-1:0]      n_pairs;
   logic                    half_held;
   logic [CHAR_W-1:0]       held_char;
   logic signed [LON_W-1:0] lon_acc;
   logic signed [LAT_W-1:0] lat_acc;
   logic signed [LON_W-1:0] lon_cell;
   logic signed [LAT_W-1:0] lat_cell;
   status_type              first_err;
   logic [1:0]              whole_pairs;

   function automatic bit is_blank(input logic [CHAR_W-1:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic [CHAR_W-1:0] upcase(input logic [CHAR_W-1:0] c);
      return (c >= CH_LO_A && c <= CH_LO_Z) ? c - CASE_GAP : c;
   endfunction

   function automatic void restart_locator();
      n_pairs     = '0;
      half_held   = 1'b0;
      held_char   = '0;
      lon_acc     = LON_MIN;
      lat_acc     = LAT_MIN;
      lon_cell    = LON_W'(360 * ONE_DEG);
      lat_cell    = LAT_W'(180 * ONE_DEG);
      first_err   = ST_OK;
      whole_pairs = '0;
   endfunction

   // refine the cell by one pair; the first error freezes the position
   function automatic void take_pair(input logic [CHAR_W-1:0] a_in,
                                     input logic [CHAR_W-1:0] b_in);
      logic [CHAR_W-1:0] a;
      logic [CHAR_W-1:0] b;
      longint            lon_step;
      longint            lat_step;
      if (whole_pairs < 2) whole_pairs++;
      if (first_err != ST_OK) return;
      if (n_pairs >= MAX_PAIRS) begin
         first_err = ST_TOO_LONG;
         return;
      end
      if (n_pairs == 0) begin
         a = upcase(a_in);
         b = upcase(b_in);
         if (a < CH_UP_A || a > CH_UP_R || b < CH_UP_A || b > CH_UP_R) begin
            first_err = ST_BAD_FIELD;
            return;
         end
         lon_cell = LON_W'(20 * ONE_DEG);
         lat_cell = LAT_W'(10 * ONE_DEG);
         lon_step = a - CH_UP_A;
         lat_step = b - CH_UP_A;
      end else if (n_pairs[0]) begin
         a = a_in;
         b = b_in;
         if (a < CH_ZERO || a > CH_NINE || b < CH_ZERO || b > CH_NINE) begin
            first_err = ST_BAD_DIGIT;
            return;
         end
         lon_cell = lon_cell / 10;
         lat_cell = lat_cell / 10;
         lon_step = a - CH_ZERO;
         lat_step = b - CH_ZERO;
      end else begin
         a = upcase(a_in);
         b = upcase(b_in);
         if (a < CH_UP_A || a > CH_UP_X || b < CH_UP_A || b > CH_UP_X) begin
            first_err = ST_BAD_LETTER;
            return;
         end
         lon_cell = lon_cell / 24;
         lat_cell = lat_cell / 24;
         lon_step = a - CH_UP_A;
         lat_step = b - CH_UP_A;
      end
      lon_acc = lon_acc + LON_W'(lon_step * longint'(lon_cell));
      lat_acc = lat_acc + LAT_W'(lat_step * longint'(lat_cell));
      n_pairs++;
   endfunction

   function automatic void feed_char(input logic [CHAR_W-1:0] c, input logic fin);
      fix_type f;
      longint  lon_c;
      longint  lat_c;
      if (!is_blank(c)) begin
         if (!half_held) begin
            held_char = c;
            half_held = 1'b1;
         end else begin
            half_held = 1'b0;
            take_pair(held_char, c);
         end
      end
      if (!fin) return;
      f.status = (half_held || whole_pairs < 2) ? ST_BAD_LEN : first_err;
      f.lat    = '0;
      f.lon    = '0;
      if (f.status == ST_OK) begin
         lon_c = longint'(lon_acc) + (longint'(lon_cell) >>> 1);
         lat_c = longint'(lat_acc) + (longint'(lat_cell) >>> 1);
         if (lon_c < LON_MIN) lon_c = LON_MIN;
         if (lon_c > LON_MAX) lon_c = LON_MAX;
         if (lat_c < LAT_MIN) lat_c = LAT_MIN;
         if (lat_c > LAT_MAX) lat_c = LAT_MAX;
         f.lon = LON_OUT_W'(lon_c);
         f.lat = LAT_OUT_W'(lat_c);
      end
      f.pairs = n_pairs;
      fix_q = {fix_q, f};
      restart_locator();
   endfunction

   always @(posedge clock) begin
      fix_type want;
      if (reset) begin
         restart_locator();
         fix_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            fixes_checked++;
            if (fix_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: result with nothing pending: lat %0d lon %0d status %0d pairs %0d",
                           $time, rsp_mon.lat_fixed, rsp_mon.lon_fixed, rsp_mon.status,
                           rsp_mon.pairs_used);
            end else begin
               want = fix_q.pop_front();
               if (want.status == ST_OK) fixes_good++;
               if (rsp_mon.lat_fixed !== want.lat || rsp_mon.lon_fixed !== want.lon ||
                   rsp_mon.status !== want.status || rsp_mon.pairs_used !== want.pairs) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: mismatch: expected lat %0d lon %0d status %0d pairs %0d",
                              $time, want.lat, want.lon, want.status, want.pairs);
                     $display("%0t:           actual   lat %0d lon %0d status %0d pairs %0d",
                              $time, rsp_mon.lat_fixed, rsp_mon.lon_fixed, rsp_mon.status,
                              rsp_mon.pairs_used);
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            feed_char(req_mon.grid_char, req_mon.last);
      end
      fixes_pending <= fix_q.size();
   end

endmodule

FILE: tb/sv/tb_maidenhead_locator_to_latlon_unit.sv
`timescale 1ns / 1ps

module tb_maidenhead_locator_to_latlon_unit;
   import mhl_pkg::*;

   localparam int CHAR_TARGET  = 1250;
   localparam int IDLE_LIMIT   = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_AT      = 40;
   localparam int DRAIN_CYCLES = 8;

   // characters just outside the accepted ranges
   localparam logic [CHAR_W-1:0] NEAR_MISS [0:8] = '{
      8'h40, 8'h53, 8'h59, 8'h2F, 8'h3A, 8'h60, 8'h7B, 8'h73, 8'h79
   };

   logic clock = 1'b0;
   logic reset;

   mhl_req_if req_ch();
   mhl_rsp_if rsp_ch();

   int fail_count;
   int fixes_pending;
   int fixes_checked;
   int fixes_good;
   int chars_sent;
   bit steady_send;
   logic [CHAR_W-1:0] loc_q[$];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   maidenhead_locator_to_latlon_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   mhl_locator_checker chk (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .fail_count    (fail_count),
      .fixes_pending (fixes_pending),
      .fixes_checked (fixes_checked),
      .fixes_good    (fixes_good)
   );

   task automatic send_char(input logic [CHAR_W-1:0] c, input logic fin);
      int gap;
      gap = steady_send ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.grid_char <= c;
      req_ch.last      <= fin;
      do @(posedge clock); while (!req_ch.ready);
      chars_sent++;
   endtask

   task automatic send_locator();
      steady_send = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < loc_q.size(); i++)
         send_char(loc_q[i], i == loc_q.size() - 1);
   endtask

   task automatic send_text(input string s);
      loc_q.delete();
      for (int i = 0; i < s.len(); i++)
         loc_q = {loc_q, s[i]};
      send_locator();
   endtask

   function automatic logic [CHAR_W-1:0] any_blank();
      return ($urandom_range(0, 5) == 0) ? CH_SPACE :
             CHAR_W'($urandom_range(CH_TAB, CH_CR));
   endfunction

   function automatic logic [CHAR_W-1:0] pair_char(input int p);
      logic [CHAR_W-1:0] c;
      if (p == 0)
         c = CH_UP_A + CHAR_W'($urandom_range(0, 17));
      else if (p % 2 == 1)
         return CH_ZERO + CHAR_W'($urandom_range(0, 9));
      else
         c = CH_UP_A + CHAR_W'($urandom_range(0, 23));
      return $urandom_range(0, 1) ? c + CASE_GAP : c;
   endfunction

   // mostly well-formed locators; the rest short, long, odd, corrupted or noise
   task automatic build_random_locator();
      int kind;
      int n_pairs;
      kind = $urandom_range(0, 19);
      loc_q.delete();
      if (kind == 0) begin
         repeat ($urandom_range(1, 10)) loc_q = {loc_q, CHAR_W'($urandom)};
         return;
      end
      if (kind <= 2)
         n_pairs = $urandom_range(MAX_PAIRS + 1, 8);
      else if (kind == 3)
         n_pairs = $urandom_range(0, 1);
      else
         n_pairs = $urandom_range(2, MAX_PAIRS);
      for (int p = 0; p < n_pairs; p++) begin
         for (int j = 0; j < 2; j++) begin
            if ($urandom_range(0, 11) == 0) loc_q = {loc_q, any_blank()};
            loc_q = {loc_q, pair_char(p)};
         end
      end
      if (kind == 4)
         loc_q = {loc_q, pair_char(n_pairs)};
      if ((kind == 5 || kind == 6) && loc_q.size() > 0)
         loc_q[$urandom_range(0, loc_q.size() - 1)] = ($urandom_range(0, 1) == 0) ?
            NEAR_MISS[$urandom_range(0, 8)] : CHAR_W'($urandom);
      if (kind == 7 || loc_q.size() == 0)
         loc_q = {loc_q, any_blank()};
   endtask

   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.grid_char <= '0;
      req_ch.last      <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_text("aa00");
      loc_q = '{8'hFF, CH_UP_A, 8'h00, CH_SPACE};
      send_locator();
      send_text("RR");
      send_text("AA0a");
      send_text("AA00y0");
      send_text("RR99xx99XX00");

      while (chars_sent < CHAR_TARGET) begin
         build_random_locator();
         send_locator();
      end
      req_ch.valid <= 1'b0;

      @(posedge clock);
      while (fixes_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d characters; checked %0d locator results, %0d decoded and %0d refused.",
               chars_sent, fixes_checked, fixes_good, fixes_checked - fixes_good);
      $display("Covered every status code, blanks, case folding and a %0d-cycle output stall.",
               HOLD_CYCLES);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // hold off once for a long stretch so the request path backs up
   initial begin
      int served;
      int stall;
      bit eager;
      served = 0;
      eager  = 1'b0;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (served % 16 == 0) eager = ($urandom_range(0, 2) == 0);
         if (served == HOLD_AT)
            stall = HOLD_CYCLES;
         else
            stall = eager ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         served++;
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle = 0;
         else
            idle++;
      end
      $display("Watchdog: no request or result moved for %0d cycles", IDLE_LIMIT);
      $display("Verification failed");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/mhl_pkg.sv
hdl/mhl_req_if.sv
hdl/mhl_rsp_if.sv
hdl/mhl_decode.sv
hdl/mhl_finish.sv
hdl/maidenhead_locator_to_latlon_unit.sv
tb/sv/mhl_locator_checker.sv
tb/sv/tb_maidenhead_locator_to_latlon_unit.sv
